FILE: hdl/bfc_pkg.sv
// Package for the bounded FIFO channel with end-of-stream and abort tracking.
// Holds action and status codes and the default sizes. Depends on nothing.
package bfc_pkg;

  // Default sizes handed to the top level parameters.
  localparam int DEPTH_DEF         = 256;
  localparam int PAYLOAD_WIDTH_DEF = 32;
  localparam int MAX_PRODUCERS_DEF = 255;

  // Fixed field widths.
  localparam int ACT_W = 3;
  localparam int ST_W  = 3;
  localparam int CFG_W = 9;

  // Capacity limits.
  localparam int CAP_MIN   = 2;
  localparam int CAP_RESET = 256;

  typedef logic [ACT_W-1:0] action_t;
  typedef logic [ST_W-1:0]  status_t;

  // Action codes.
  localparam action_t ACT_PUSH  = 3'd0;
  localparam action_t ACT_POP   = 3'd1;
  localparam action_t ACT_DRAIN = 3'd2;
  localparam action_t ACT_REG   = 3'd3;
  localparam action_t ACT_DONE  = 3'd4;
  localparam action_t ACT_ABORT = 3'd5;
  localparam action_t ACT_QUERY = 3'd6;

  // Status codes.
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_FULL      = 3'd1;
  localparam status_t ST_EMPTY     = 3'd2;
  localparam status_t ST_EOS       = 3'd3;
  localparam status_t ST_ABORTED   = 3'd4;
  localparam status_t ST_AFTER_EOS = 3'd5;
  localparam status_t ST_INTR      = 3'd6;
  localparam status_t ST_PROTO     = 3'd7;

endpackage

FILE: hdl/bounded_fifo_channel_with_eos_abort.sv
// Top level of the bounded FIFO channel with end-of-stream and abort tracking.
// Depends on bfc_pkg for action codes, status codes and default sizes.
//
// Usage:
//   The input channel (in_valid / in_stall) carries one request item: an
//   action (push, pop, drain, register producer, producer done, abort,
//   query), a payload word for push and the caller's interrupt flag.
//   The result channel (out_valid / out_stall) returns exactly one result
//   item per request: status, dequeued word, occupancy and the flags.
//   The configuration channel (cfg_valid / cfg_ready) writes the capacity,
//   clamped to 2..DEPTH; it is always ready. The user must write it only
//   while idle; the block itself does not enforce this. A request is
//   registered in the middle stage at the accepting edge and moves into the
//   result register, raising out_valid, once that register is free. One item
//   is taken every cycle while the receiver keeps up; the bound is the single
//   read port of the slot memory, whose registered read data is picked up by
//   the result register as the middle stage advances. When the receiver stalls,
//   the result register holds and one more item is still accepted into the
//   middle stage; after that in_stall rises until the result is taken.
//   Reset empties the FIFO, clears the producer counts and both flags and
//   loads the capacity with 256 (or DEPTH if smaller). Slot contents are
//   not cleared; no slot is read before it has been written.
module bounded_fifo_channel_with_eos_abort #(
  parameter int DEPTH         = bfc_pkg::DEPTH_DEF,
  parameter int PAYLOAD_WIDTH = bfc_pkg::PAYLOAD_WIDTH_DEF,
  parameter int MAX_PRODUCERS = bfc_pkg::MAX_PRODUCERS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Request channel.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bfc_pkg::action_t                 in_action,
  input  logic [PAYLOAD_WIDTH-1:0]         in_payload,
  input  logic                             in_interrupted,
  // Result channel.
  output logic                             out_valid,
  input  logic                             out_stall,
  output bfc_pkg::status_t                 out_status,
  output logic [PAYLOAD_WIDTH-1:0]         out_payload_out,
  output logic [$clog2(DEPTH+1)-1:0]       out_occupancy,
  output logic                             out_is_full,
  output logic                             out_is_empty,
  output logic                             out_abort_flag,
  output logic                             out_eos_flag,
  // Capacity write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bfc_pkg::CFG_W-1:0]        cfg_capacity
);

  import bfc_pkg::*;

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH+1);
  localparam int PROD_W  = $clog2(MAX_PRODUCERS+1);
  localparam int CAP_RST = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

  // Architectural state.
  logic [PAYLOAD_WIDTH-1:0] slot_mem [DEPTH];
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  cap_r;
  logic [PROD_W-1:0] reg_cnt_r, reg_cnt_nxt;
  logic [PROD_W-1:0] fin_cnt_r, fin_cnt_nxt;
  logic              abort_r, abort_nxt;
  logic              eos_r, eos_nxt;

  // Middle stage, waiting for the memory read data.
  logic                     s1_valid_r;
  status_t                  s1_status_r;
  logic                     s1_take_r;
  logic [CNT_W-1:0]         s1_occ_r;
  logic                     s1_full_r;
  logic                     s1_empty_r;
  logic                     s1_abort_r;
  logic                     s1_eos_r;
  logic [PAYLOAD_WIDTH-1:0] mem_q_r;

  // Result register.
  logic                     out_valid_r;
  status_t                  out_status_r;
  logic [PAYLOAD_WIDTH-1:0] out_payload_r;
  logic [CNT_W-1:0]         out_occ_r;
  logic                     out_full_r;
  logic                     out_empty_r;
  logic                     out_abort_r;
  logic                     out_eos_r;

  // Request decode results.
  status_t     status_c;
  logic        push_c;
  logic        take_c;
  logic        in_fire;
  logic        s1_adv;
  logic [31:0] cap_clamped;

  // Handshake: the middle stage moves on whenever the result register frees.
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Clamp a capacity write to 2..DEPTH.
  always_comb begin
    cap_clamped = 32'(cfg_capacity);
    if (cap_clamped < 32'(CAP_MIN)) begin
      cap_clamped = 32'(CAP_MIN);
    end else if (cap_clamped > 32'(DEPTH)) begin
      cap_clamped = 32'(DEPTH);
    end
  end

  // Decode one request item against the current state.
  always_comb begin
    status_c    = ST_OK;
    push_c      = 1'b0;
    take_c      = 1'b0;
    reg_cnt_nxt = reg_cnt_r;
    fin_cnt_nxt = fin_cnt_r;
    abort_nxt   = abort_r;
    eos_nxt     = eos_r;
    case (in_action)
      ACT_PUSH: begin
        if (abort_r) begin
          status_c = ST_ABORTED;
        end else if (eos_r) begin
          status_c = ST_AFTER_EOS;
        end else if (in_interrupted) begin
          status_c = ST_INTR;
        end else if (count_r >= cap_r) begin
          status_c = ST_FULL;
        end else begin
          push_c = 1'b1;
        end
      end
      ACT_POP: begin
        if (abort_r) begin
          status_c = ST_ABORTED;
        end else if (count_r != '0) begin
          take_c = 1'b1;
        end else if (eos_r) begin
          status_c = ST_EOS;
        end else if (in_interrupted) begin
          status_c = ST_INTR;
        end else begin
          status_c = ST_EMPTY;
        end
      end
      ACT_DRAIN: begin
        if (count_r != '0) begin
          take_c = 1'b1;
        end else begin
          status_c = ST_EMPTY;
        end
      end
      ACT_REG: begin
        if (eos_r || fin_cnt_r != '0 || reg_cnt_r >= PROD_W'(MAX_PRODUCERS)) begin
          status_c = ST_PROTO;
        end else begin
          reg_cnt_nxt = reg_cnt_r + 1'b1;
        end
      end
      ACT_DONE: begin
        if (fin_cnt_r >= reg_cnt_r) begin
          status_c = ST_PROTO;
        end else begin
          fin_cnt_nxt = fin_cnt_r + 1'b1;
          if (fin_cnt_nxt == reg_cnt_r) begin
            eos_nxt = 1'b1;
          end
        end
      end
      ACT_ABORT: begin
        abort_nxt = 1'b1;
      end
      ACT_QUERY: begin
        status_c = ST_OK;
      end
      default: begin
        status_c = ST_PROTO;
      end
    endcase
  end

  // Ring pointers and entry count after this item.
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (push_c) begin
      tail_nxt  = (tail_r == PTR_W'(DEPTH-1)) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end
    if (take_c) begin
      head_nxt  = (head_r == PTR_W'(DEPTH-1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
  end

  // Control state update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      cap_r     <= CNT_W'(CAP_RST);
      reg_cnt_r <= '0;
      fin_cnt_r <= '0;
      abort_r   <= 1'b0;
      eos_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= CNT_W'(cap_clamped);
      end
      if (in_fire) begin
        head_r    <= head_nxt;
        tail_r    <= tail_nxt;
        count_r   <= count_nxt;
        reg_cnt_r <= reg_cnt_nxt;
        fin_cnt_r <= fin_cnt_nxt;
        abort_r   <= abort_nxt;
        eos_r     <= eos_nxt;
      end
    end
  end

  // Slot memory: write on push, registered read on a successful take.
  always_ff @(posedge clk) begin
    if (in_fire && push_c) begin
      slot_mem[tail_r] <= in_payload;
    end
    if (in_fire && take_c) begin
      mem_q_r <= slot_mem[head_r];
    end
  end

  // Middle stage valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Middle stage payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_status_r <= status_c;
      s1_take_r   <= take_c;
      s1_occ_r    <= count_nxt;
      s1_full_r   <= (count_nxt >= cap_r);
      s1_empty_r  <= (count_nxt == '0);
      s1_abort_r  <= abort_nxt;
      s1_eos_r    <= eos_nxt;
    end
  end

  // Result register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload; the word is zero unless an entry was taken.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status_r  <= s1_status_r;
      out_payload_r <= s1_take_r ? mem_q_r : '0;
      out_occ_r     <= s1_occ_r;
      out_full_r    <= s1_full_r;
      out_empty_r   <= s1_empty_r;
      out_abort_r   <= s1_abort_r;
      out_eos_r     <= s1_eos_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_payload_out = out_payload_r;
  assign out_occupancy   = out_occ_r;
  assign out_is_full     = out_full_r;
  assign out_is_empty    = out_empty_r;
  assign out_abort_flag  = out_abort_r;
  assign out_eos_flag    = out_eos_r;

  // The entry count never passes the ring size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count exceeds ring depth");

  // An empty ring has its head and tail pointers together.
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> head_r == tail_r)
    else $error("empty ring with split pointers");

  // Finished producers never outnumber registered ones.
  a_prod_order: assert property (@(posedge clk) disable iff (!rst_n)
    fin_cnt_r <= reg_cnt_r)
    else $error("more producers finished than registered");

  // End of stream means every registered producer has finished.
  a_eos_done: assert property (@(posedge clk) disable iff (!rst_n)
    eos_r |-> (fin_cnt_r == reg_cnt_r) && (reg_cnt_r != '0))
    else $error("end of stream with producers still open");

  // Abort is sticky until reset.
  a_abort_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    abort_r |=> abort_r)
    else $error("abort flag cleared without reset");

endmodule
